// ----- sv/dmht_pkg.sv -----
// Package: shared types, codes and helpers of the min-heap timer queue.
`timescale 1ns / 1ps
package dmht_pkg;

    localparam int HEAP_DEPTH_DEF = 64;
    localparam int ID_SPACE_DEF   = 1024;
    localparam int ID_W           = 10;
    localparam int DL_W           = 32;
    localparam int DUR_W          = 30;
    localparam int CNT_W          = 7;
    localparam int WAIT_W         = 31;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_ADJUST = 3'd1,
        KIND_FIRE   = 3'd2,
        KIND_TICK   = 3'd3,
        KIND_POP    = 3'd4,
        KIND_CLEAR  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK_POS,
        ST_LOOK_SLOT,
        ST_REM0,
        ST_REM1,
        ST_DOWN0,
        ST_DOWN1,
        ST_DOWN2,
        ST_DOWN3,
        ST_UP0,
        ST_UP1,
        ST_PLACE,
        ST_ROOT_RD,
        ST_ROOT_CAP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
    } entry_t;

    // Deadline a is earlier than b when the wrapped difference is negative
    function automatic logic earlier(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
        logic [DL_W-1:0] diff;
        diff = a - b;
        return diff[DL_W-1];
    endfunction

endpackage

// ----- sv/dmht_if.sv -----
// Interfaces: command and result channels of the min-heap timer queue.
`timescale 1ns / 1ps
interface dmht_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                kind;
    logic [dmht_pkg::ID_W-1:0] timer_id;
    logic [dmht_pkg::DUR_W-1:0] duration;

    modport source (output valid, output kind, output timer_id, output duration, input ready);
    modport sink (input valid, input kind, input timer_id, input duration, output ready);
endinterface

interface dmht_res_if;
    logic                               valid;
    logic                               ready;
    logic                               fired;
    logic [dmht_pkg::ID_W-1:0]          fired_id;
    logic [1:0]                         status;
    logic [dmht_pkg::CNT_W-1:0]         entry_count;
    logic signed [dmht_pkg::WAIT_W-1:0] next_wait;
    logic                               last;

    modport source (output valid, output fired, output fired_id, output status,
                    output entry_count, output next_wait, output last, input ready);
    modport sink (input valid, input fired, input fired_id, input status,
                  input entry_count, input next_wait, input last, output ready);
endinterface

// ----- sv/dmht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dmht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/deadline_min_heap_timer.sv -----
// Top level: timer queue kept as a binary min-heap with an id-to-slot table.
//
// Usage: commands enter on cmd (valid/ready); results leave on res
// (valid/ready), one or more per command, the final one marked by last.
// A tick gives one result per fired timer, earliest first (one if none is due).
// The block takes one command at a time: cmd.ready is high only while it
// is idle. A command does a lookup (slot table, then heap slot), then the
// sift: walking down and walking up level by level, placing the moving
// entry, reading the root for the wait, and holding the result in the
// output register. One heap RAM read port sets the pace.
// Each further timer fired by a tick costs one removal sift more.
// Reset empties the queue and clears the time counter at once; no clearing
// pass runs, since presence is checked against the live heap slot.
// While res is stalled the result holds in its register and no new
// command is taken.
`timescale 1ns / 1ps
module deadline_min_heap_timer #(
    parameter int HEAP_DEPTH = dmht_pkg::HEAP_DEPTH_DEF,
    parameter int ID_SPACE   = dmht_pkg::ID_SPACE_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    dmht_cmd_if.sink   cmd,
    dmht_res_if.source res
);
    import dmht_pkg::*;

    localparam int SW  = $clog2(HEAP_DEPTH);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int XW  = SW + 2;
    localparam int IAW = $clog2(ID_SPACE);
    localparam int EW  = $bits(entry_t);

    // RAM ports
    logic           heap_we;
    logic [SW-1:0]  heap_waddr;
    entry_t         heap_wdata;
    logic [SW-1:0]  heap_raddr;
    logic [EW-1:0]  heap_rbits;
    entry_t         heap_rdata;
    logic           pos_we;
    logic [IAW-1:0] pos_waddr;
    logic [SW-1:0]  pos_wdata;
    logic [IAW-1:0] pos_raddr;
    logic [SW-1:0]  pos_rdata;

    assign heap_rdata = entry_t'(heap_rbits);

    dmht_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rbits)
    );

    dmht_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_pos (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // Registers
    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [DUR_W-1:0]     dur_reg, dur_next;
    logic [DL_W-1:0]      now_reg, now_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [SW-1:0]        p_reg, p_next;
    logic [SW-1:0]        i_reg, i_next;
    entry_t               e_reg, e_next;
    entry_t               sel_reg, sel_next;
    logic [SW-1:0]        sel_idx_reg, sel_idx_next;
    logic                 moved_reg, moved_next;
    logic                 fire_reg, fire_next;
    logic [ID_W-1:0]      fid_reg, fid_next;
    status_t              status_reg, status_next;
    logic [ID_W-1:0]      root_id_reg, root_id_next;
    logic                 o_fired_reg, o_fired_next;
    logic [ID_W-1:0]      o_fid_reg, o_fid_next;
    status_t              o_status_reg, o_status_next;
    logic [CW-1:0]        o_count_reg, o_count_next;
    logic [WAIT_W-1:0]    o_wait_reg, o_wait_next;
    logic                 o_last_reg, o_last_next;

    // Index arithmetic
    logic [XW-1:0] child_a;
    logic [XW-1:0] child_b;
    logic [XW-1:0] limit_x;
    logic [SW-1:0] parent_idx;
    logic [CW-1:0] count_m1;
    logic          known;
    logic          present;
    logic [DL_W-1:0] new_dl;
    logic [DL_W-1:0] root_diff;
    logic          due;
    logic          is_tick;

    assign child_a    = XW'({i_reg, 1'b1});
    assign child_b    = XW'({i_reg, 1'b0}) + XW'(2);
    assign limit_x    = XW'(count_reg);
    assign parent_idx = (i_reg - 1'b1) >> 1;
    assign count_m1   = count_reg - 1'b1;
    assign known      = (int'(id_reg) < ID_SPACE);
    assign present    = known && (XW'(p_reg) < limit_x) && (heap_rdata.id == id_reg);
    assign new_dl     = now_reg + DL_W'(dur_reg);
    assign root_diff  = heap_rdata.dl - now_reg;
    assign due        = (count_reg != '0) && ((root_diff == '0) || root_diff[DL_W-1]);
    assign is_tick    = (kind_reg == KIND_TICK);

    // State and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            now_reg   <= '0;
            fire_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            now_reg   <= now_next;
            fire_reg  <= fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        dur_reg      <= dur_next;
        p_reg        <= p_next;
        i_reg        <= i_next;
        e_reg        <= e_next;
        sel_reg      <= sel_next;
        sel_idx_reg  <= sel_idx_next;
        moved_reg    <= moved_next;
        fid_reg      <= fid_next;
        status_reg   <= status_next;
        root_id_reg  <= root_id_next;
        o_fired_reg  <= o_fired_next;
        o_fid_reg    <= o_fid_next;
        o_status_reg <= o_status_next;
        o_count_reg  <= o_count_next;
        o_wait_reg   <= o_wait_next;
        o_last_reg   <= o_last_next;
    end

    // Sequencer: lookup, removal, sift down and up, root read, emit
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        dur_next      = dur_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        p_next        = p_reg;
        i_next        = i_reg;
        e_next        = e_reg;
        sel_next      = sel_reg;
        sel_idx_next  = sel_idx_reg;
        moved_next    = moved_reg;
        fire_next     = fire_reg;
        fid_next      = fid_reg;
        status_next   = status_reg;
        root_id_next  = root_id_reg;
        o_fired_next  = o_fired_reg;
        o_fid_next    = o_fid_reg;
        o_status_next = o_status_reg;
        o_count_next  = o_count_reg;
        o_wait_next   = o_wait_reg;
        o_last_next   = o_last_reg;

        heap_we    = 1'b0;
        heap_waddr = i_reg;
        heap_wdata = e_reg;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = IAW'(e_reg.id);
        pos_wdata  = i_reg;
        pos_raddr  = IAW'(cmd.timer_id);

        cmd.ready = 1'b0;
        res.valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    kind_next   = kind_t'(cmd.kind);
                    id_next     = cmd.timer_id;
                    dur_next    = cmd.duration;
                    status_next = STAT_OK;
                    fire_next   = 1'b0;
                    if (kind_t'(cmd.kind) == KIND_TICK)
                    begin
                        now_next = now_reg + DL_W'(cmd.duration);
                    end
                    state_next = ST_LOOK_POS;
                end
            end

            ST_LOOK_POS:
            begin
                heap_raddr = pos_rdata;
                p_next     = pos_rdata;
                state_next = ST_LOOK_SLOT;
            end

            ST_LOOK_SLOT:
            begin
                moved_next = 1'b0;
                e_next.id  = id_reg;
                e_next.dl  = new_dl;
                state_next = ST_ROOT_RD;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (!known)
                        begin
                            status_next = STAT_UNKNOWN;
                        end
                        else if (present)
                        begin
                            i_next     = p_reg;
                            state_next = ST_DOWN0;
                        end
                        else if (int'(count_reg) >= HEAP_DEPTH)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            i_next     = count_reg[SW-1:0];
                            count_next = count_reg + 1'b1;
                            state_next = ST_UP0;
                        end
                    end
                    KIND_ADJUST:
                    begin
                        if (present)
                        begin
                            i_next     = p_reg;
                            state_next = ST_DOWN0;
                        end
                        else
                        begin
                            status_next = STAT_UNKNOWN;
                        end
                    end
                    KIND_FIRE:
                    begin
                        if (present)
                        begin
                            fire_next  = 1'b1;
                            fid_next   = id_reg;
                            i_next     = p_reg;
                            state_next = ST_REM0;
                        end
                    end
                    KIND_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            i_next     = '0;
                            state_next = ST_REM0;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = ST_ROOT_RD;
                    end
                endcase
            end

            // Remove slot i: shrink, then fetch the last entry to refill the hole
            ST_REM0:
            begin
                count_next = count_m1;
                heap_raddr = count_m1[SW-1:0];
                state_next = ST_REM1;
            end

            ST_REM1:
            begin
                e_next     = heap_rdata;
                moved_next = 1'b0;
                if (XW'(i_reg) < limit_x)
                begin
                    state_next = ST_DOWN0;
                end
                else
                begin
                    state_next = ST_ROOT_RD;
                end
            end

            // Sift down: read left child
            ST_DOWN0:
            begin
                heap_raddr = child_a[SW-1:0];
                if (child_a < limit_x)
                begin
                    state_next = ST_DOWN1;
                end
                else if (moved_reg)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_UP0;
                end
            end

            // Hold left child, read right child if there is one
            ST_DOWN1:
            begin
                sel_next     = heap_rdata;
                sel_idx_next = child_a[SW-1:0];
                heap_raddr   = child_b[SW-1:0];
                if (child_b < limit_x)
                begin
                    state_next = ST_DOWN2;
                end
                else
                begin
                    state_next = ST_DOWN3;
                end
            end

            ST_DOWN2:
            begin
                if (earlier(heap_rdata.dl, sel_reg.dl))
                begin
                    sel_next     = heap_rdata;
                    sel_idx_next = child_b[SW-1:0];
                end
                state_next = ST_DOWN3;
            end

            // Stop if the moving entry is strictly earlier, else pull child up
            ST_DOWN3:
            begin
                if (earlier(e_reg.dl, sel_reg.dl))
                begin
                    state_next = moved_reg ? ST_PLACE : ST_UP0;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wdata = sel_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = IAW'(sel_reg.id);
                    i_next     = sel_idx_reg;
                    moved_next = 1'b1;
                    state_next = ST_DOWN0;
                end
            end

            // Sift up: read parent
            ST_UP0:
            begin
                heap_raddr = parent_idx;
                if (i_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_UP1;
                end
            end

            ST_UP1:
            begin
                if (earlier(heap_rdata.dl, e_reg.dl))
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = IAW'(heap_rdata.id);
                    i_next     = parent_idx;
                    state_next = ST_UP0;
                end
            end

            // Drop the moving entry into the hole
            ST_PLACE:
            begin
                heap_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = ST_ROOT_RD;
            end

            ST_ROOT_RD:
            begin
                heap_raddr = '0;
                state_next = ST_ROOT_CAP;
            end

            // Build the result from the root, or start firing a due root
            ST_ROOT_CAP:
            begin
                root_id_next = heap_rdata.id;
                if (is_tick && !fire_reg && due)
                begin
                    fire_next  = 1'b1;
                    fid_next   = heap_rdata.id;
                    i_next     = '0;
                    state_next = ST_REM0;
                end
                else
                begin
                    o_fired_next  = fire_reg;
                    o_fid_next    = fire_reg ? fid_reg : '0;
                    o_status_next = status_reg;
                    o_count_next  = count_reg;
                    o_last_next   = !(is_tick && due);
                    if (count_reg == '0)
                    begin
                        o_wait_next = '1;
                    end
                    else if (root_diff[DL_W-1])
                    begin
                        o_wait_next = '0;
                    end
                    else if (root_diff[DL_W-2])
                    begin
                        o_wait_next = {1'b0, {(WAIT_W-1){1'b1}}};
                    end
                    else
                    begin
                        o_wait_next = root_diff[WAIT_W-1:0];
                    end
                    state_next = ST_OUT;
                end
            end

            // Hold the result until taken; a tick goes on with the next due root
            ST_OUT:
            begin
                res.valid = 1'b1;
                if (res.ready)
                begin
                    if (o_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        fid_next   = root_id_reg;
                        i_next     = '0;
                        state_next = ST_REM0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result payload
    assign res.fired       = o_fired_reg;
    assign res.fired_id    = o_fid_reg;
    assign res.status      = o_status_reg;
    assign res.entry_count = CNT_W'(o_count_reg);
    assign res.next_wait   = o_wait_reg;
    assign res.last        = o_last_reg;

endmodule
